/* rtl/sds_pkg.sv */
// shared types and constants for the sparse dot-product scaler
// no dependencies
package sds_pkg;

  localparam int LIST_DEPTH = 64;
  localparam int INDEX_BITS = 16;
  localparam int ADDR_W     = $clog2(LIST_DEPTH);
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int VALUE_W    = 17;
  localparam int ENTRY_W    = INDEX_BITS + VALUE_W;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [VALUE_W-1:0] ONE_Q16 = 17'd65536;

  typedef enum logic [1:0] {
    CMD_LOAD_A  = 2'd0,
    CMD_LOAD_B  = 2'd1,
    CMD_COMPUTE = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_OVERFLOW = 2'd1,
    STATUS_ORDER    = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_ACC,
    ST_SCALE,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] index;
    logic [16:0] value;
  } req_t;

  typedef struct packed {
    logic [16:0] result;
    logic [6:0]  matches_res;
    logic [1:0]  status;
  } rsp_t;

  // classified operation passed from front to back
  typedef struct packed {
    cmd_e                  op;
    logic [INDEX_BITS-1:0] index;
    logic [VALUE_W-1:0]    value;
  } op_t;

endpackage

/* rtl/sds_ram.sv */
// generic single-write, single-read memory with registered read data
// no dependencies
module sds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/sds_fifo.sv */
// short operation queue between front and back
// depends on sds_pkg
module sds_fifo
  import sds_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  op_t  push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output op_t  pop_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  op_t              mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             push;
  logic             pop;

  assign push_ready = (count != (PTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

/* rtl/sds_front.sv */
// front end: accepts request transactions, clamps values, drops unused commands
// depends on sds_pkg
module sds_front
  import sds_pkg::*;
(
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic push_valid,
  input  logic push_ready,
  output op_t  push_data
);

  logic keep;

  // unused command is consumed without entering the queue
  assign keep       = (req.cmd != CMD_NONE);
  assign req_ready  = push_ready;
  assign push_valid = req_valid && keep;

  always_comb begin
    push_data.op    = cmd_e'(req.cmd);
    push_data.index = req.index[INDEX_BITS-1:0];
    push_data.value = (req.value > ONE_Q16) ? ONE_Q16 : req.value;
  end

endmodule

/* rtl/sds_back.sv */
// back end: list loading, merge walk, scaling and result register
// depends on sds_pkg and sds_ram
module sds_back
  import sds_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic op_valid,
  output logic op_ready,
  input  op_t  op,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  state_t                state, state_next;
  logic [CNT_W-1:0]      a_count, b_count;
  logic [INDEX_BITS-1:0] a_last, b_last;
  logic [1:0]            error_code;
  logic [CNT_W-1:0]      ia, ib;
  logic [CNT_W-1:0]      match_cnt;
  logic [VALUE_W-1:0]    sum;
  logic [VALUE_W-1:0]    weight;
  logic [33:0]           prod;

  logic [ENTRY_W-1:0]    rdata_a, rdata_b;
  logic [INDEX_BITS-1:0] ka, kb;
  logic [VALUE_W-1:0]    va, vb;
  logic                  we_a, we_b;
  logic                  load_a, load_b;
  logic                  a_full, b_full, a_bad, b_bad;
  logic                  more;
  logic [34:0]           rounded_full;
  logic [17:0]           rnd;
  logic [18:0]           acc;
  logic [VALUE_W-1:0]    res_sat;

  assign ka = rdata_a[ENTRY_W-1:VALUE_W];
  assign va = rdata_a[VALUE_W-1:0];
  assign kb = rdata_b[ENTRY_W-1:VALUE_W];
  assign vb = rdata_b[VALUE_W-1:0];

  assign op_ready = (state == ST_IDLE);
  assign load_a   = op_valid && op_ready && (op.op == CMD_LOAD_A);
  assign load_b   = op_valid && op_ready && (op.op == CMD_LOAD_B);
  assign a_full   = (a_count == CNT_W'(LIST_DEPTH));
  assign b_full   = (b_count == CNT_W'(LIST_DEPTH));
  assign a_bad    = (a_count != '0) && (op.index <= a_last);
  assign b_bad    = (b_count != '0) && (op.index <= b_last);
  assign we_a     = load_a && !a_full && !a_bad;
  assign we_b     = load_b && !b_full && !b_bad;
  assign more     = (ia < a_count) && (ib < b_count);

  // rounding to q1.16 and saturation
  assign rounded_full = {1'b0, prod} + 35'd32768;
  assign rnd          = rounded_full[33:16];
  assign acc          = {2'b00, sum} + {1'b0, rnd};
  assign res_sat      = (rnd > 18'(ONE_Q16)) ? ONE_Q16 : rnd[VALUE_W-1:0];

  sds_ram #(.WIDTH(ENTRY_W), .DEPTH(LIST_DEPTH)) u_ram_a (
    .clk  (clk),
    .we   (we_a),
    .waddr(a_count[ADDR_W-1:0]),
    .wdata({op.index, op.value}),
    .raddr(ia[ADDR_W-1:0]),
    .rdata(rdata_a)
  );

  sds_ram #(.WIDTH(ENTRY_W), .DEPTH(LIST_DEPTH)) u_ram_b (
    .clk  (clk),
    .we   (we_b),
    .waddr(b_count[ADDR_W-1:0]),
    .wdata({op.index, op.value}),
    .raddr(ib[ADDR_W-1:0]),
    .rdata(rdata_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (op_valid && op.op == CMD_COMPUTE) state_next = ST_RD;
      end
      ST_RD:    state_next = more ? ST_CMP : ST_SCALE;
      ST_CMP:   state_next = (ka == kb) ? ST_ACC : ST_RD;
      ST_ACC:   state_next = ST_RD;
      ST_SCALE: state_next = ST_FIN;
      ST_FIN: begin
        if (!rsp_valid || rsp_ready) state_next = ST_IDLE;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_count    <= '0;
      b_count    <= '0;
      error_code <= STATUS_OK;
      rsp_valid  <= 1'b0;
    end else begin
      // a new result in ST_FIN takes the place of the one leaving
      if (rsp_valid && rsp_ready && state != ST_FIN) rsp_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (we_a) begin
            a_count <= a_count + 1'b1;
            a_last  <= op.index;
          end
          if (we_b) begin
            b_count <= b_count + 1'b1;
            b_last  <= op.index;
          end
          // first error wins
          if (error_code == STATUS_OK) begin
            if ((load_a && a_full) || (load_b && b_full)) begin
              error_code <= STATUS_OVERFLOW;
            end else if ((load_a && a_bad) || (load_b && b_bad)) begin
              error_code <= STATUS_ORDER;
            end
          end
          ia        <= '0;
          ib        <= '0;
          match_cnt <= '0;
          sum       <= '0;
          weight    <= op.value;
        end
        ST_CMP: begin
          if (ka == kb) begin
            prod      <= va * vb;
            match_cnt <= match_cnt + 1'b1;
            ia        <= ia + 1'b1;
            ib        <= ib + 1'b1;
          end else if (ka > kb) begin
            ib <= ib + 1'b1;
          end else begin
            ia <= ia + 1'b1;
          end
        end
        ST_ACC: begin
          sum <= (acc > 19'(ONE_Q16)) ? ONE_Q16 : acc[VALUE_W-1:0];
        end
        ST_SCALE: begin
          prod <= sum * weight;
        end
        ST_FIN: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid <= 1'b1;
            if (error_code != STATUS_OK) begin
              rsp.result      <= '0;
              rsp.matches_res <= '0;
            end else begin
              rsp.result      <= res_sat;
              rsp.matches_res <= match_cnt;
            end
            rsp.status <= error_code;
            a_count    <= '0;
            b_count    <= '0;
            error_code <= STATUS_OK;
          end
        end
        default: ;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    a_count <= CNT_W'(LIST_DEPTH) && b_count <= CNT_W'(LIST_DEPTH))
    else $error("list count beyond depth");

  walk_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_CMP |-> ia < a_count && ib < b_count)
    else $error("merge walk read past list end");

  err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != STATUS_OK |-> rsp.result == '0 && rsp.matches_res == '0)
    else $error("error result carries data");

  match_bound: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> match_cnt <= ia && match_cnt <= ib)
    else $error("match count exceeds walk position");

endmodule

/* rtl/sparse_dot_scale.sv */
// sparse_dot_scale: scaled dot product of two sparse q1.16 vectors
// depends on sds_pkg, sds_front, sds_fifo, sds_back, sds_ram
//
// Usage: req carries one transaction per item (cmd, index, value); cmd load
// A/B appends an entry to a list, compute merges both lists by index, sums
// rounded products of matched values, scales by the weight in value and
// returns one rsp transaction (result, matches_res, status). Unused command
// 3 is consumed and ignored. Lists and the sticky error clear after compute.
// Throughput: the front queues up to 4 items, one per cycle while the queue
// is not full; the back retires a load as soon as it takes it. A compute is
// taken in the idle state, then runs merge steps (registered list memory
// read, then compare), each match adding an accumulate step, then ends the
// walk, scales and registers the result; no new item is taken until idle.
// The merge walk over the list memories sets the time a compute takes.
// Reset (rst, synchronous) empties lists, queue and error; no clearing pass.
// A stalled rsp holds its result register; the back waits on it, the queue
// keeps taking req items until full.
module sparse_dot_scale
  import sds_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  logic push_valid, push_ready;
  op_t  push_data;
  logic op_valid, op_ready;
  op_t  op;

  sds_front u_front (
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data)
  );

  sds_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (op_valid),
    .pop_ready (op_ready),
    .pop_data  (op)
  );

  sds_back u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (op_valid),
    .op_ready (op_ready),
    .op       (op),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

endmodule

/* dv/sparse_dot_scale_test.sv */
// testbench for sparse_dot_scale: scaled dot product of two sparse lists
// depends on sds_pkg and the rtl top; self-checking against a local predictor
module sparse_dot_scale_test;
  import sds_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  sparse_dot_scale uut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  // predictor state
  logic [15:0] a_idx[LIST_DEPTH];
  logic [16:0] a_val[LIST_DEPTH];
  logic [15:0] b_idx[LIST_DEPTH];
  logic [16:0] b_val[LIST_DEPTH];
  int unsigned a_len, b_len;
  logic [1:0] sticky_err;

  rsp_t expected_rsp[$];
  int errors;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_off;
  int quiet_cycles;
  bit sending;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [16:0] clamp_q16(logic [16:0] v);
    return (v > ONE_Q16) ? ONE_Q16 : v;
  endfunction

  function automatic void append_entry(bit to_b, logic [15:0] idx, logic [16:0] val);
    int unsigned n;
    n = to_b ? b_len : a_len;
    if (n >= LIST_DEPTH) begin
      if (sticky_err == STATUS_OK) sticky_err = STATUS_OVERFLOW;
      return;
    end
    if (n > 0 && idx <= (to_b ? b_idx[n-1] : a_idx[n-1])) begin
      if (sticky_err == STATUS_OK) sticky_err = STATUS_ORDER;
      return;
    end
    if (to_b) begin
      b_idx[n] = idx; b_val[n] = val; b_len = n + 1;
    end else begin
      a_idx[n] = idx; a_val[n] = val; a_len = n + 1;
    end
  endfunction

  function automatic rsp_t scaled_dot(logic [16:0] weight);
    rsp_t r;
    int unsigned ia, ib, hits;
    longint unsigned acc, res;
    ia = 0; ib = 0; hits = 0; acc = 0;
    while (ia < a_len && ib < b_len) begin
      if (a_idx[ia] == b_idx[ib]) begin
        acc += (longint'(a_val[ia]) * b_val[ib] + 32768) >> 16;
        if (acc > 65536) acc = 65536;
        hits++; ia++; ib++;
      end else if (a_idx[ia] > b_idx[ib]) ib++;
      else ia++;
    end
    res = (acc * weight + 32768) >> 16;
    if (res > 65536) res = 65536;
    r.status = sticky_err;
    if (sticky_err != STATUS_OK) begin
      r.result = '0; r.matches_res = '0;
    end else begin
      r.result = res[16:0]; r.matches_res = hits[6:0];
    end
    a_len = 0; b_len = 0; sticky_err = STATUS_OK;
    return r;
  endfunction

  function automatic void predict(req_t t);
    logic [16:0] v;
    v = clamp_q16(t.value);
    case (cmd_e'(t.cmd))
      CMD_LOAD_A: append_entry(1'b0, t.index, v);
      CMD_LOAD_B: append_entry(1'b1, t.index, v);
      CMD_COMPUTE: expected_rsp.push_back(scaled_dot(v));
      default: ;
    endcase
  endfunction

  // valid stays high into the next item; drain drops it at the end
  task automatic send_item(logic [1:0] cmd, logic [15:0] idx, logic [16:0] val);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= '{cmd: cmd, index: idx, value: val};
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    predict('{cmd: cmd, index: idx, value: val});
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (3 * 2 * LIST_DEPTH + 20) @(posedge clk);
  endtask

  // receiver ready and checking
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_rsp.size() == 0) begin
          $display("%0t: unexpected transaction, actual %p", $time, rsp);
          errors++;
        end else begin
          rsp_t e;
          e = expected_rsp.pop_front();
          if (e.result !== rsp.result || e.matches_res !== rsp.matches_res ||
              e.status !== rsp.status) begin
            $display("%0t: mismatch, expected %p actual %p", $time, e, rsp);
            errors++;
          end
        end
      end
      rsp_ready <= !hold_off && !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready) || !sending)
      quiet_cycles <= 0;
    else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic load_list(bit to_b, int n, logic [15:0] step_max);
    logic [15:0] idx;
    idx = 16'($urandom_range(3));
    repeat (n) begin
      send_item(to_b ? CMD_LOAD_B : CMD_LOAD_A, idx, 17'($urandom_range(65536)));
      idx = idx + 16'($urandom_range(step_max, 1));
    end
  endtask

  task automatic test_directed();
    // full-scale values, max weight, saturation
    send_item(CMD_LOAD_A, 16'd0, 17'd65536);
    send_item(CMD_LOAD_A, 16'hffff, 17'h1ffff);
    send_item(CMD_LOAD_B, 16'd0, 17'h1ffff);
    send_item(CMD_LOAD_B, 16'hffff, 17'd65536);
    send_item(CMD_COMPUTE, 16'hffff, 17'h1ffff);
    // empty lists, zero weight, ignored command
    send_item(CMD_NONE, 16'h1234, 17'h15555);
    send_item(CMD_COMPUTE, 16'd0, 17'd0);
    // rounding half up
    send_item(CMD_LOAD_A, 16'd5, 17'd1);
    send_item(CMD_LOAD_B, 16'd5, 17'd32768);
    send_item(CMD_COMPUTE, 16'h0, 17'd65536);
    // repeated index is dropped and reported
    send_item(CMD_LOAD_A, 16'd9, 17'd100);
    send_item(CMD_LOAD_A, 16'd9, 17'd100);
    send_item(CMD_COMPUTE, 16'h0, 17'd65536);
    // list overflow on both lists
    load_list(1'b0, LIST_DEPTH + 1, 16'd3);
    send_item(CMD_COMPUTE, 16'h0, 17'd65536);
    load_list(1'b1, LIST_DEPTH + 1, 16'd3);
    send_item(CMD_COMPUTE, 16'h0, 17'd65536);
    // full lists that match all 64 entries
    for (int i = 0; i < LIST_DEPTH; i++) send_item(CMD_LOAD_A, 16'(i), 17'd1024);
    for (int i = 0; i < LIST_DEPTH; i++) send_item(CMD_LOAD_B, 16'(i), 17'd1024);
    send_item(CMD_COMPUTE, 16'h0, 17'd65536);
    drain();
  endtask

  task automatic test_random(int n_items);
    int sent;
    sent = 0;
    while (sent < n_items) begin
      int k;
      k = $urandom_range(99);
      if (k < 80) begin
        int na, nb;
        na = ($urandom_range(9) == 0) ? $urandom_range(LIST_DEPTH) : $urandom_range(6);
        nb = ($urandom_range(9) == 0) ? $urandom_range(LIST_DEPTH) : $urandom_range(6);
        load_list(1'b0, na, 16'($urandom_range(3, 1)));
        load_list(1'b1, nb, 16'($urandom_range(3, 1)));
        send_item(CMD_COMPUTE, 16'($urandom), 17'($urandom_range(65536)));
        sent += na + nb + 1;
      end else begin
        send_item(2'($urandom_range(3)), 16'($urandom), 17'($urandom));
        sent++;
      end
    end
    send_item(CMD_COMPUTE, 16'($urandom), 17'($urandom));
    drain();
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      repeat (12) begin
        send_item(CMD_LOAD_A, 16'd1, 17'd40000);
        send_item(CMD_LOAD_B, 16'd1, 17'd50000);
        send_item(CMD_COMPUTE, 16'd0, 17'd60000);
      end
    join
    drain();
  endtask

  initial begin
    errors = 0; send_idle_pct = 0; recv_stall_pct = 0; hold_off = 1'b0;
    sending = 1'b0; a_len = 0; b_len = 0; sticky_err = STATUS_OK;
    rst = 1'b1; req_valid = 1'b0; req = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    sending = 1'b1;
    test_directed();
    test_random(60);
    send_idle_pct = 86;
    test_random(60);
    send_idle_pct = 0; recv_stall_pct = 86;
    test_random(60);
    send_idle_pct = 21; recv_stall_pct = 21;
    test_random(60);
    send_idle_pct = 0; recv_stall_pct = 0;
    test_backpressure();
    sending = 1'b0;
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

/* files.f */
rtl/sds_pkg.sv
rtl/sds_ram.sv
rtl/sds_fifo.sv
rtl/sds_front.sv
rtl/sds_back.sv
rtl/sparse_dot_scale.sv
dv/sparse_dot_scale_test.sv
